// ===== design/script_token_scanner_core_defines.svh =====
// Assertion macros for the script token scanner checker.
`ifndef SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define STS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define STS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/sts_pkg.sv =====
// Package of types, character constants and classifiers for the script token scanner.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int TEXT_MAX_DEF = 64;

    typedef enum logic [3:0] {
        K_EOF     = 4'd0,
        K_IDENT   = 4'd1,
        K_NUMBER  = 4'd2,
        K_STRING  = 4'd3,
        K_PLUS    = 4'd4,
        K_MINUS   = 4'd5,
        K_STAR    = 4'd6,
        K_SLASH   = 4'd7,
        K_LPAREN  = 4'd8,
        K_RPAREN  = 4'd9,
        K_ASSIGN  = 4'd10,
        K_COMMA   = 4'd11,
        K_DOT     = 4'd12,
        K_CONCAT  = 4'd13,
        K_UNKNOWN = 4'd14
    } t_kind;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_EQUAL  = 8'h3D;
    localparam logic [7:0] C_BSL    = 8'h5C;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_LOW_N  = 8'h6E;
    localparam logic [7:0] C_LOW_T  = 8'h74;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       valid;
        logic       tend;
    } t_tok;

    // Up to two result words produced by one source byte.
    typedef struct packed {
        t_tok [1:0] item;
        logic [1:0] n;
    } t_emit;

    function automatic t_emit emit(t_emit e, t_kind k, logic [7:0] ch, logic v, logic te);
        t_emit r;
        r = e;
        if (e.n < 2'd2) begin
            r.item[e.n[0]] = '{kind: k, ch: ch, valid: v, tend: te};
            r.n            = e.n + 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'd32) || (b inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b inside {[8'd48:8'd57]};
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return b inside {[8'd65:8'd90], [8'd97:8'd122]};
    endfunction

    function automatic logic is_id_start(logic [7:0] b);
        return is_alpha(b) || (b == C_UNDER);
    endfunction

    function automatic logic is_id_body(logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == C_UNDER);
    endfunction

    function automatic t_kind op_kind(logic [7:0] b);
        t_kind k;
        case (b)
            C_PLUS:   k = K_PLUS;
            C_MINUS:  k = K_MINUS;
            C_STAR:   k = K_STAR;
            C_SLASH:  k = K_SLASH;
            C_LPAREN: k = K_LPAREN;
            C_RPAREN: k = K_RPAREN;
            C_EQUAL:  k = K_ASSIGN;
            C_COMMA:  k = K_COMMA;
            C_DOT:    k = K_DOT;
            default:  k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ===== design/sts_ifs.sv =====
// Valid/ready channel interfaces for source bytes and token words.
`timescale 1ns / 1ps

interface sts_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface sts_tok_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] text_char;
    logic       char_valid;
    logic       token_end;

    modport source (output valid, output token_kind, output text_char, output char_valid,
                    output token_end, input ready);
    modport sink (input valid, input token_kind, input text_char, input char_valid,
                  input token_end, output ready);
endinterface

// ===== design/script_token_scanner_core.sv =====
// The token words of a source byte are written into the output queue when the byte is taken.
// One source byte per cycle while each byte yields at most one word and the output is not
// stalled; the single-word output port drains a byte's two words one at a time.
// A four-word output queue decouples the sides; bytes are taken while two words are free.
// Synchronous active-low reset returns the scanner to idle and empties the output queue.
`timescale 1ns / 1ps

module script_token_scanner_core #(
    parameter int TEXT_MAX = sts_pkg::TEXT_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sts_src_if.sink   i_src,
    sts_tok_if.source o_tok
);

    localparam int CW = $clog2(TEXT_MAX);
    localparam logic [CW-1:0] LIMIT = CW'(TEXT_MAX - 1);
    localparam int QD = 4;
    localparam int PW = $clog2(QD);
    localparam int NW = $clog2(QD + 1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_ESCAPE,
        M_FULL,
        M_PEND
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [7:0]     r_pend, n_pend;

    sts_pkg::t_tok  r_q [QD];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_fill, n_fill;

    sts_pkg::t_emit e;
    logic           push, pop;
    logic           fin, fresh, sch_go;
    logic [7:0]     b, sch;

    assign i_src.ready = (r_fill <= NW'(QD - 2));
    assign push        = i_src.valid && i_src.ready;
    assign o_tok.valid = (r_fill != '0);
    assign pop         = o_tok.valid && o_tok.ready;

    assign o_tok.token_kind = r_q[r_rd].kind;
    assign o_tok.text_char  = r_q[r_rd].ch;
    assign o_tok.char_valid = r_q[r_rd].valid;
    assign o_tok.token_end  = r_q[r_rd].tend;

    assign b   = i_src.source_byte;
    assign fin = i_src.end_of_source || (b == sts_pkg::C_NUL);

    always_comb begin
        e      = '0;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_pend = r_pend;
        fresh  = 1'b0;
        sch_go = 1'b0;
        sch    = b;

        if (fin) begin
            case (r_mode)
                M_IDENT:  e = sts_pkg::emit(e, sts_pkg::K_IDENT, 8'd0, 1'b0, 1'b1);
                M_NUMBER: e = sts_pkg::emit(e, sts_pkg::K_NUMBER, 8'd0, 1'b0, 1'b1);
                M_STRING, M_ESCAPE: begin
                    e = sts_pkg::emit(e, sts_pkg::K_STRING, 8'd0, 1'b0, 1'b1);
                end
                M_PEND: begin
                    e = sts_pkg::emit(e, sts_pkg::op_kind(r_pend), r_pend, 1'b1, 1'b1);
                end
                default: ;
            endcase
            e      = sts_pkg::emit(e, sts_pkg::K_EOF, 8'd0, 1'b0, 1'b1);
            n_mode = M_IDLE;
            n_cnt  = '0;
            n_pend = '0;
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (b == sts_pkg::C_LF) n_mode = M_IDLE;
                end
                M_IDENT: begin
                    if (sts_pkg::is_id_body(b)) begin
                        if (n_cnt < LIMIT) begin
                            e     = sts_pkg::emit(e, sts_pkg::K_IDENT, b, 1'b1, 1'b0);
                            n_cnt = CW'(n_cnt + 1'b1);
                        end
                    end else begin
                        e     = sts_pkg::emit(e, sts_pkg::K_IDENT, 8'd0, 1'b0, 1'b1);
                        fresh = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (sts_pkg::is_digit(b) || (b == sts_pkg::C_DOT)) begin
                        if (n_cnt < LIMIT) begin
                            e     = sts_pkg::emit(e, sts_pkg::K_NUMBER, b, 1'b1, 1'b0);
                            n_cnt = CW'(n_cnt + 1'b1);
                        end
                    end else begin
                        e     = sts_pkg::emit(e, sts_pkg::K_NUMBER, 8'd0, 1'b0, 1'b1);
                        fresh = 1'b1;
                    end
                end
                M_STRING: begin
                    if (b == sts_pkg::C_QUOTE) begin
                        e      = sts_pkg::emit(e, sts_pkg::K_STRING, 8'd0, 1'b0, 1'b1);
                        n_mode = M_IDLE;
                        n_cnt  = '0;
                    end else if (b == sts_pkg::C_BSL) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        sch_go = 1'b1;
                    end
                end
                M_ESCAPE: begin
                    sch_go = 1'b1;
                    if (b == sts_pkg::C_LOW_N) sch = sts_pkg::C_LF;
                    else if (b == sts_pkg::C_LOW_T) sch = sts_pkg::C_TAB;
                end
                M_FULL: begin
                    // A closing quote right after a full string is swallowed.
                    if (b == sts_pkg::C_QUOTE) begin
                        n_mode = M_IDLE;
                        n_cnt  = '0;
                    end else begin
                        fresh = 1'b1;
                    end
                end
                M_PEND: begin
                    n_pend = '0;
                    if (r_pend == sts_pkg::C_MINUS && b == sts_pkg::C_MINUS) begin
                        n_mode = M_COMMENT;
                    end else if ((r_pend inside {sts_pkg::C_MINUS, sts_pkg::C_PLUS})
                                 && sts_pkg::is_digit(b)) begin
                        n_mode = M_NUMBER;
                        n_cnt  = '0;
                        if (n_cnt < LIMIT) begin
                            e     = sts_pkg::emit(e, sts_pkg::K_NUMBER, r_pend, 1'b1, 1'b0);
                            n_cnt = CW'(n_cnt + 1'b1);
                        end
                        if (n_cnt < LIMIT) begin
                            e     = sts_pkg::emit(e, sts_pkg::K_NUMBER, b, 1'b1, 1'b0);
                            n_cnt = CW'(n_cnt + 1'b1);
                        end
                    end else if (r_pend == sts_pkg::C_DOT && b == sts_pkg::C_DOT) begin
                        e      = sts_pkg::emit(e, sts_pkg::K_CONCAT, sts_pkg::C_DOT, 1'b1, 1'b0);
                        e      = sts_pkg::emit(e, sts_pkg::K_CONCAT, sts_pkg::C_DOT, 1'b1, 1'b1);
                        n_mode = M_IDLE;
                    end else begin
                        e     = sts_pkg::emit(e, sts_pkg::op_kind(r_pend), r_pend, 1'b1, 1'b1);
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase

            // One decoded string character; a string that fills up is closed here.
            if (sch_go) begin
                if (n_cnt < LIMIT) begin
                    e     = sts_pkg::emit(e, sts_pkg::K_STRING, sch, 1'b1, 1'b0);
                    n_cnt = CW'(n_cnt + 1'b1);
                end
                n_mode = M_STRING;
                if (n_cnt >= LIMIT) begin
                    e      = sts_pkg::emit(e, sts_pkg::K_STRING, 8'd0, 1'b0, 1'b1);
                    n_mode = M_FULL;
                    n_cnt  = '0;
                end
            end

            // The byte is handled as in the idle state: a space is skipped, any other byte starts a new token.
            if (fresh) begin
                n_mode = M_IDLE;
                n_cnt  = '0;
                if (sts_pkg::is_space(b)) begin
                    n_mode = M_IDLE;
                end else if (sts_pkg::is_id_start(b)) begin
                    n_mode = M_IDENT;
                    if (n_cnt < LIMIT) begin
                        e     = sts_pkg::emit(e, sts_pkg::K_IDENT, b, 1'b1, 1'b0);
                        n_cnt = CW'(n_cnt + 1'b1);
                    end
                end else if (sts_pkg::is_digit(b)) begin
                    n_mode = M_NUMBER;
                    if (n_cnt < LIMIT) begin
                        e     = sts_pkg::emit(e, sts_pkg::K_NUMBER, b, 1'b1, 1'b0);
                        n_cnt = CW'(n_cnt + 1'b1);
                    end
                end else if (b inside {sts_pkg::C_MINUS, sts_pkg::C_PLUS, sts_pkg::C_DOT}) begin
                    n_mode = M_PEND;
                    n_pend = b;
                end else if (b == sts_pkg::C_QUOTE) begin
                    n_mode = M_STRING;
                end else begin
                    e = sts_pkg::emit(e, sts_pkg::op_kind(b), b, 1'b1, 1'b1);
                end
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (push) n_fill = n_fill + NW'(e.n);
        if (pop)  n_fill = n_fill - NW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_pend <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_pend <= n_pend;
                r_wr   <= r_wr + PW'(e.n);
            end
            if (pop) r_rd <= r_rd + PW'(1);
            r_fill <= n_fill;
        end
        if (push && e.n != 2'd0) r_q[r_wr] <= e.item[0];
        if (push && e.n == 2'd2) r_q[r_wr + PW'(1)] <= e.item[1];
    end

endmodule

// ===== design/sts_checker.sv =====
// Port-level checker for the script token scanner, bound to the scanner core module.
`timescale 1ns / 1ps
`include "script_token_scanner_core_defines.svh"

module sts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_kind,
    input logic [7:0] i_char,
    input logic       i_char_valid,
    input logic       i_token_end
);

    // A stalled word keeps its contents.
    `STS_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_char) && $stable(i_char_valid) && $stable(i_token_end), "stalled token word changed")

    // The queue is empty and open right after reset.
    `STS_ASSERT_RST(a_rst_empty, !i_rst_n |=> !i_out_valid && i_in_ready, "queue not empty after reset")

    // A word without a character is always a token end marker with a zero character.
    `STS_ASSERT(a_marker, i_out_valid && !i_char_valid |-> i_token_end && (i_char == 8'd0), "bad end marker word")

    // End of file words carry no character and close their token.
    `STS_ASSERT(a_eof, i_out_valid && (i_kind == sts_pkg::K_EOF) |-> !i_char_valid && i_token_end, "bad eof word")

endmodule

bind script_token_scanner_core sts_checker u_sts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_src.ready),
    .i_out_valid  (o_tok.valid),
    .i_out_ready  (o_tok.ready),
    .i_kind       (o_tok.token_kind),
    .i_char       (o_tok.text_char),
    .i_char_valid (o_tok.char_valid),
    .i_token_end  (o_tok.token_end)
);
